/* rtl/hht_pkg.sv */
package hht_pkg;

	localparam int NUM_DOFS  = 1024;
	localparam int IDX_W     = $clog2(NUM_DOFS);
	localparam int DATA_W    = 32;
	localparam int COEF_W    = 48;
	localparam int FRAC_W    = 24;
	localparam int CFG_IDX_W = 3;
	localparam int ACC_W     = 60;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_A1    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_A2    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_A3    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_A4    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_C3    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_C4    = 3'd6;

	// action codes
	localparam logic [1:0] ACT_LOAD    = 2'd0;
	localparam logic [1:0] ACT_PREDICT = 2'd1;
	localparam logic [1:0] ACT_CORRECT = 2'd2;
	localparam logic [1:0] ACT_COMMIT  = 2'd3;

	localparam logic signed [COEF_W-1:0] Q_ONE  = 48'sd16777216;
	localparam logic signed [COEF_W-1:0] Q_MONE = -48'sd16777216;
	localparam logic signed [ACC_W-1:0]  Q_HALF = 60'sd8388608;

	typedef struct packed {
		logic signed [COEF_W-1:0] alpha;
		logic signed [COEF_W-1:0] a1;
		logic signed [COEF_W-1:0] a2;
		logic signed [COEF_W-1:0] a3;
		logic signed [COEF_W-1:0] a4;
		logic signed [COEF_W-1:0] c3;
		logic signed [COEF_W-1:0] c4;
	} coef_t;

	typedef struct packed {
		logic load;
		logic predict;
		logic correct;
		logic commit;
	} kind_t;

	typedef struct packed {
		kind_t                    kind;
		logic [IDX_W-1:0]         dof;
		logic signed [DATA_W-1:0] disp;
		logic signed [DATA_W-1:0] vel;
		logic signed [DATA_W-1:0] accel;
		logic signed [DATA_W-1:0] delta;
	} work_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] val;
		logic                     sat;
	} sat_t;

	typedef struct packed {
		logic              accept;
		logic              pop;
		logic [QCNT_W-1:0] count;
	} front_stat_t;

	typedef struct packed {
		logic issue;
		logic hazard;
	} back_stat_t;

	// clamp a wide value to 32 bits
	function automatic sat_t sat32(input logic signed [ACC_W-1:0] v);
		sat_t r;
		if (v[ACC_W-1:DATA_W-1] != {(ACC_W-DATA_W+1){v[ACC_W-1]}}) begin
			r.sat = 1'b1;
			r.val = v[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		end else begin
			r.sat = 1'b0;
			r.val = v[DATA_W-1:0];
		end
		return r;
	endfunction

	// add high part to rounded low part, then clamp
	function automatic sat_t mac_fin(input logic signed [ACC_W-1:0] hsum,
			input logic signed [ACC_W-1:0] lsum);
		logic signed [ACC_W-1:0] t;
		t = lsum + Q_HALF;
		return sat32(hsum + (t >>> FRAC_W));
	endfunction

endpackage

/* rtl/hht_chan_if.sv */
interface hht_req_if;
	import hht_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [1:0]               action;
	logic [IDX_W-1:0]         dof_index;
	logic signed [DATA_W-1:0] disp_in;
	logic signed [DATA_W-1:0] vel_in;
	logic signed [DATA_W-1:0] accel_in;
	logic signed [DATA_W-1:0] delta_in;
	modport source (output valid, action, dof_index, disp_in, vel_in, accel_in, delta_in,
		input ready);
	modport sink (input valid, action, dof_index, disp_in, vel_in, accel_in, delta_in,
		output ready);
endinterface

interface hht_rsp_if;
	import hht_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [IDX_W-1:0]         dof_out;
	logic signed [DATA_W-1:0] disp_out;
	logic signed [DATA_W-1:0] vel_out;
	logic signed [DATA_W-1:0] accel_out;
	logic                     saturated;
	modport source (output valid, dof_out, disp_out, vel_out, accel_out, saturated,
		input ready);
	modport sink (input valid, dof_out, disp_out, vel_out, accel_out, saturated,
		output ready);
endinterface

/* rtl/hht_ram.sv */
module hht_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

/* rtl/hht_front.sv */
module hht_front (
	input  logic                clk,
	input  logic                arst_n,
	hht_req_if.sink             req,
	output hht_pkg::work_t      head,
	output logic                head_valid,
	input  logic                head_pop,
	output hht_pkg::front_stat_t stat
);
	import hht_pkg::*;

	work_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              accept;
	logic              pop;
	work_t             word;

	// classify the incoming word
	always_comb begin
		word.kind  = '0;
		word.dof   = req.dof_index;
		word.disp  = req.disp_in;
		word.vel   = req.vel_in;
		word.accel = req.accel_in;
		word.delta = req.delta_in;
		case (req.action)
			ACT_LOAD:    word.kind.load    = 1'b1;
			ACT_PREDICT: word.kind.predict = 1'b1;
			ACT_CORRECT: word.kind.correct = 1'b1;
			ACT_COMMIT:  word.kind.commit  = 1'b1;
			default:     word.kind.commit  = 1'b1;
		endcase
	end

	assign req.ready  = (count_q != QCNT_W'(QDEPTH));
	assign accept     = req.valid && req.ready;
	assign head_valid = (count_q != '0);
	assign pop        = head_pop && head_valid;
	assign head       = mem_q[rd_ptr_q];

	// store accepted words
	always_ff @(posedge clk) begin
		if (accept) begin
			mem_q[wr_ptr_q] <= word;
		end
	end

	// advance queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (accept && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (!accept && pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign stat.accept = accept;
	assign stat.pop    = pop;
	assign stat.count  = count_q;
endmodule

/* rtl/hht_back.sv */
module hht_back (
	input  logic               clk,
	input  logic               arst_n,
	input  hht_pkg::coef_t     coef,
	input  hht_pkg::work_t     head,
	input  logic               head_valid,
	output logic               head_pop,
	hht_rsp_if.source          rsp,
	output hht_pkg::back_stat_t stat
);
	import hht_pkg::*;

	localparam int NOW_W  = 3 * DATA_W;
	localparam int PREV_W = 2 * DATA_W;
	localparam int HP_W   = 24 + DATA_W;
	localparam int LP_W   = 25 + DATA_W;
	localparam int BHP_W  = 24 + DATA_W + 1;
	localparam int BLP_W  = 25 + DATA_W + 1;

	logic adv;
	logic hazard;
	logic issue;

	logic               vld_s1, vld_s2, vld_s3, vld_s4;
	work_t              w_s1, w_s2, w_s3;
	logic [NOW_W-1:0]   now_rd;
	logic [PREV_W-1:0]  prev_rd;
	logic [NOW_W-1:0]   now_wdata;
	logic [PREV_W-1:0]  prev_wdata;
	logic               now_we, prev_we;

	// stage 1 operands
	logic signed [DATA_W-1:0] d1, v1, a1v, dp1, vp1;
	logic signed [COEF_W-1:0] cv1, cv2, ca1, ca2;
	logic signed [DATA_W-1:0] xv1, xv2, xa1, xa2;

	// stage 2 registers
	logic signed [HP_W-1:0]   hv1_s2, hv2_s2, ha1_s2, ha2_s2;
	logic signed [LP_W-1:0]   lv1_s2, lv2_s2, la1_s2, la2_s2;
	logic signed [DATA_W-1:0] d_s2, v_s2, a_s2, dp_s2, vp_s2;
	sat_t                     vmac, amac, dsum;
	logic signed [DATA_W-1:0] dn2, vn2, an2;
	logic                     sat2;

	// stage 3 registers
	logic signed [DATA_W-1:0] dn_s3, vn_s3, an_s3, d_s3, v_s3, dp_s3, vp_s3;
	logic                     sat_s3;
	logic signed [DATA_W:0]   ddiff, vdiff;
	logic signed [DATA_W-1:0] vbase;

	// stage 4 registers
	kind_t                    k_s4;
	logic [IDX_W-1:0]         dof_s4;
	logic signed [BHP_W-1:0]  hd_s4, hv_s4;
	logic signed [BLP_W-1:0]  ld_s4, lv_s4;
	logic signed [DATA_W-1:0] dn_s4, vn_s4, an_s4, dp_s4, vb_s4;
	logic                     sat_s4;
	sat_t                     dbl, vbl;

	// result register
	logic                     rsp_valid_q;
	logic [IDX_W-1:0]         dof_q;
	logic signed [DATA_W-1:0] disp_q, vel_q, accel_q;
	logic                     sat_q;

	// move the whole pipe only when the result register can take a word
	assign adv    = !rsp_valid_q || rsp.ready;
	assign hazard = (vld_s1 && w_s1.dof == head.dof) ||
			(vld_s2 && w_s2.dof == head.dof) ||
			(vld_s3 && w_s3.dof == head.dof);
	assign issue    = adv && head_valid && !hazard;
	assign head_pop = issue;

	hht_ram #(.WIDTH(NOW_W), .DEPTH(NUM_DOFS)) u_now (
		.clk(clk), .we(now_we), .waddr(w_s3.dof), .wdata(now_wdata),
		.re(adv), .raddr(head.dof), .rdata(now_rd)
	);

	hht_ram #(.WIDTH(PREV_W), .DEPTH(NUM_DOFS)) u_prev (
		.clk(clk), .we(prev_we), .waddr(w_s3.dof), .wdata(prev_wdata),
		.re(adv), .raddr(head.dof), .rdata(prev_rd)
	);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s1      <= issue;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			vld_s4      <= vld_s3;
			rsp_valid_q <= vld_s4;
		end
	end

	// capture the issued word alongside its state read
	always_ff @(posedge clk) begin
		if (adv) begin
			w_s1 <= head;
		end
	end

	// select predictor or corrector operands
	always_comb begin
		d1  = now_rd[3*DATA_W-1:2*DATA_W];
		v1  = now_rd[2*DATA_W-1:DATA_W];
		a1v = now_rd[DATA_W-1:0];
		dp1 = prev_rd[2*DATA_W-1:DATA_W];
		vp1 = prev_rd[DATA_W-1:0];
		if (w_s1.kind.predict) begin
			cv1 = coef.a1; xv1 = v1;  cv2 = coef.a2; xv2 = a1v;
			ca1 = coef.a4; xa1 = a1v; ca2 = coef.a3; xa2 = v1;
		end else begin
			cv1 = Q_ONE; xv1 = v1;  cv2 = coef.c4; xv2 = w_s1.delta;
			ca1 = Q_ONE; xa1 = a1v; ca2 = coef.c3; xa2 = w_s1.delta;
		end
	end

	// split products: signed high half and unsigned low half of each coefficient
	always_ff @(posedge clk) begin
		if (adv) begin
			w_s2   <= w_s1;
			hv1_s2 <= $signed(cv1[COEF_W-1:FRAC_W]) * xv1;
			hv2_s2 <= $signed(cv2[COEF_W-1:FRAC_W]) * xv2;
			ha1_s2 <= $signed(ca1[COEF_W-1:FRAC_W]) * xa1;
			ha2_s2 <= $signed(ca2[COEF_W-1:FRAC_W]) * xa2;
			lv1_s2 <= $signed({1'b0, cv1[FRAC_W-1:0]}) * xv1;
			lv2_s2 <= $signed({1'b0, cv2[FRAC_W-1:0]}) * xv2;
			la1_s2 <= $signed({1'b0, ca1[FRAC_W-1:0]}) * xa1;
			la2_s2 <= $signed({1'b0, ca2[FRAC_W-1:0]}) * xa2;
			d_s2   <= d1;
			v_s2   <= v1;
			a_s2   <= a1v;
			dp_s2  <= dp1;
			vp_s2  <= vp1;
		end
	end

	// round, clamp and pick the new state
	always_comb begin
		vmac = mac_fin(ACC_W'(hv1_s2) + ACC_W'(hv2_s2), ACC_W'(lv1_s2) + ACC_W'(lv2_s2));
		amac = mac_fin(ACC_W'(ha1_s2) + ACC_W'(ha2_s2), ACC_W'(la1_s2) + ACC_W'(la2_s2));
		dsum = sat32(ACC_W'(d_s2) + ACC_W'(w_s2.delta));
		dn2  = d_s2;
		vn2  = v_s2;
		an2  = a_s2;
		sat2 = 1'b0;
		if (w_s2.kind.load) begin
			dn2 = w_s2.disp;
			vn2 = w_s2.vel;
			an2 = w_s2.accel;
		end else if (w_s2.kind.predict) begin
			vn2  = vmac.val;
			an2  = amac.val;
			sat2 = vmac.sat || amac.sat;
		end else if (w_s2.kind.correct) begin
			dn2  = dsum.val;
			vn2  = vmac.val;
			an2  = amac.val;
			sat2 = dsum.sat || vmac.sat || amac.sat;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			w_s3   <= w_s2;
			dn_s3  <= dn2;
			vn_s3  <= vn2;
			an_s3  <= an2;
			d_s3   <= d_s2;
			v_s3   <= v_s2;
			dp_s3  <= dp_s2;
			vp_s3  <= vp_s2;
			sat_s3 <= sat2;
		end
	end

	// write back the state and start the blend products
	assign now_we     = adv && vld_s3 && !w_s3.kind.commit;
	assign prev_we    = adv && vld_s3 && w_s3.kind.predict;
	assign now_wdata  = {dn_s3, vn_s3, an_s3};
	assign prev_wdata = {d_s3, v_s3};
	assign vbase      = w_s3.kind.predict ? v_s3 : vp_s3;
	assign ddiff      = (DATA_W+1)'(dn_s3) - (DATA_W+1)'(dp_s3);
	assign vdiff      = (DATA_W+1)'(vn_s3) - (DATA_W+1)'(vbase);

	always_ff @(posedge clk) begin
		if (adv) begin
			k_s4   <= w_s3.kind;
			dof_s4 <= w_s3.dof;
			hd_s4  <= $signed(coef.alpha[COEF_W-1:FRAC_W]) * ddiff;
			hv_s4  <= $signed(coef.alpha[COEF_W-1:FRAC_W]) * vdiff;
			ld_s4  <= $signed({1'b0, coef.alpha[FRAC_W-1:0]}) * ddiff;
			lv_s4  <= $signed({1'b0, coef.alpha[FRAC_W-1:0]}) * vdiff;
			dn_s4  <= dn_s3;
			vn_s4  <= vn_s3;
			an_s4  <= an_s3;
			dp_s4  <= dp_s3;
			vb_s4  <= vbase;
			sat_s4 <= sat_s3;
		end
	end

	// finish the blends and load the result register
	assign dbl = mac_fin(ACC_W'(dp_s4) + ACC_W'(hd_s4), ACC_W'(ld_s4));
	assign vbl = mac_fin(ACC_W'(vb_s4) + ACC_W'(hv_s4), ACC_W'(lv_s4));

	always_ff @(posedge clk) begin
		if (adv) begin
			dof_q   <= dof_s4;
			accel_q <= an_s4;
			if (k_s4.predict) begin
				disp_q <= dn_s4;
				vel_q  <= vbl.val;
				sat_q  <= sat_s4 || vbl.sat;
			end else if (k_s4.correct) begin
				disp_q <= dbl.val;
				vel_q  <= vbl.val;
				sat_q  <= sat_s4 || dbl.sat || vbl.sat;
			end else begin
				disp_q <= dn_s4;
				vel_q  <= vn_s4;
				sat_q  <= sat_s4;
			end
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.dof_out   = dof_q;
	assign rsp.disp_out  = disp_q;
	assign rsp.vel_out   = vel_q;
	assign rsp.accel_out = accel_q;
	assign rsp.saturated = sat_q;

	assign stat.issue  = issue;
	assign stat.hazard = hazard;
endmodule

/* rtl/hht_alpha_dof_integrator.sv */
// HHT-alpha per-DOF integrator.
// req channel: one word per action (load, predict, correct, commit) on one DOF
// index; a word is taken when req.valid and req.ready are both high.
// rsp channel: one result word per request word, in request order.
// cfg port: cfg_we writes register cfg_idx (0 alpha, 1..4 a1..a4, 5 c3, 6 c4)
// with cfg_data; write only while no word is in flight.
// Throughput: one word per cycle while consecutive words in flight address
// different DOFs and no result waits on a low rsp.ready. A word whose DOF
// matches one of the three words ahead of it in the pipe waits at the queue
// head until that word has written back to the state RAMs.
// Path of a word: queue, then issue and RAM read, predictor multiply, round,
// blend multiply and result register.
// A four-word queue lets req keep accepting while rsp is stalled; when the
// queue fills, req.ready drops. A result waiting on rsp.ready holds the whole back pipe.
// Reset clears the queue, the pipe valid bits and the registers (a1, a4 to -1.0);
// DOF state is undefined until loaded.
module hht_alpha_dof_integrator (
	input  logic                               clk,
	input  logic                               arst_n,
	hht_req_if.sink                            req,
	hht_rsp_if.source                          rsp,
	input  logic                               cfg_we,
	input  logic [hht_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic signed [hht_pkg::COEF_W-1:0]  cfg_data
);
	import hht_pkg::*;

	coef_t       coef_q;
	work_t       head;
	logic        head_valid;
	logic        head_pop;
	front_stat_t fstat;
	back_stat_t  bstat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q       <= '0;
			coef_q.a1    <= Q_MONE;
			coef_q.a4    <= Q_MONE;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_ALPHA: coef_q.alpha <= cfg_data;
				REG_A1:    coef_q.a1    <= cfg_data;
				REG_A2:    coef_q.a2    <= cfg_data;
				REG_A3:    coef_q.a3    <= cfg_data;
				REG_A4:    coef_q.a4    <= cfg_data;
				REG_C3:    coef_q.c3    <= cfg_data;
				REG_C4:    coef_q.c4    <= cfg_data;
				default:   coef_q       <= coef_q;
			endcase
		end
	end

	hht_front u_front (
		.clk(clk), .arst_n(arst_n), .req(req),
		.head(head), .head_valid(head_valid), .head_pop(head_pop), .stat(fstat)
	);

	hht_back u_back (
		.clk(clk), .arst_n(arst_n), .coef(coef_q),
		.head(head), .head_valid(head_valid), .head_pop(head_pop),
		.rsp(rsp), .stat(bstat)
	);

	// never issue a word that collides with one still in flight
	a_no_hazard_issue: assert property (@(posedge clk) disable iff (!arst_n)
		bstat.issue |-> !bstat.hazard)
		else $error("word issued over an in-flight DOF");

	// queue occupancy follows accepts and issues
	a_queue_grow: assert property (@(posedge clk) disable iff (!arst_n)
		fstat.accept && !fstat.pop |=> fstat.count == $past(fstat.count) + 1'b1)
		else $error("queue count did not grow on accept");

	a_queue_shrink: assert property (@(posedge clk) disable iff (!arst_n)
		!fstat.accept && fstat.pop |=> fstat.count == $past(fstat.count) - 1'b1)
		else $error("queue count did not shrink on issue");
endmodule

/* bench/hht_alpha_dof_integrator_tb.sv */
`timescale 1ns / 1ps

module hht_alpha_dof_integrator_tb;
	import hht_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_WORDS = 240;
	localparam int POOL_SIZE   = 16;

	typedef struct {
		logic [1:0]               action;
		logic [IDX_W-1:0]         dof;
		logic signed [DATA_W-1:0] disp;
		logic signed [DATA_W-1:0] vel;
		logic signed [DATA_W-1:0] accel;
		logic signed [DATA_W-1:0] delta;
	} dof_word_t;

	typedef struct {
		logic [IDX_W-1:0]         dof;
		logic signed [DATA_W-1:0] disp;
		logic signed [DATA_W-1:0] vel;
		logic signed [DATA_W-1:0] accel;
		logic                     saturated;
	} dof_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic signed [COEF_W-1:0] cfg_data;

	hht_req_if req ();
	hht_rsp_if rsp ();

	hht_alpha_dof_integrator u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req.sink),
		.rsp      (rsp.source),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	// integrator state mirror and register copy
	logic signed [DATA_W-1:0] cur_disp [NUM_DOFS];
	logic signed [DATA_W-1:0] cur_vel [NUM_DOFS];
	logic signed [DATA_W-1:0] cur_accel [NUM_DOFS];
	logic signed [DATA_W-1:0] old_disp [NUM_DOFS];
	logic signed [DATA_W-1:0] old_vel [NUM_DOFS];
	logic signed [DATA_W-1:0] old_accel [NUM_DOFS];
	logic signed [COEF_W-1:0] coef [7];

	// generation-side view of which entries hold defined values
	bit now_loaded [NUM_DOFS];
	bit prev_loaded [NUM_DOFS];
	logic [IDX_W-1:0] dof_pool [POOL_SIZE];

	dof_word_t   pending_words[$];
	dof_result_t expected_results[$];

	int  fail_count;
	int  cycle_count;
	int  burst_left;
	int  gap_left;
	int  hold_count;
	bit  hold_req;
	int  rsp_mode;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// round a two-term Q24.24 x Q16.16 sum to Q16.16 and clamp
	function automatic logic signed [DATA_W-1:0] round_mac(input longint c1, input longint v1,
			input longint c2, input longint v2, inout bit sat);
		logic signed [127:0] acc;
		acc = c1 * v1;
		acc = acc + c2 * v2;
		acc = acc + (128'sd1 <<< (FRAC_W - 1));
		acc = acc >>> FRAC_W;
		if (acc > 128'sd2147483647) begin
			sat = 1'b1;
			return 32'sh7fffffff;
		end
		if (acc < -128'sd2147483648) begin
			sat = 1'b1;
			return 32'sh80000000;
		end
		return acc[DATA_W-1:0];
	endfunction

	function automatic logic signed [DATA_W-1:0] alpha_blend(input logic signed [DATA_W-1:0] p,
			input logic signed [DATA_W-1:0] n, inout bit sat);
		longint diff;
		diff = longint'(n) - longint'(p);
		return round_mac(longint'(Q_ONE), longint'(p), longint'(coef[REG_ALPHA]), diff, sat);
	endfunction

	// apply one accepted word to the mirror and queue its result
	function automatic void integrate_word(input dof_word_t w);
		dof_result_t r;
		bit sat;
		int i;
		logic signed [DATA_W-1:0] v0, a0;
		sat = 1'b0;
		i = w.dof;
		r.dof = w.dof;
		case (w.action)
			ACT_LOAD: begin
				cur_disp[i] = w.disp;
				cur_vel[i] = w.vel;
				cur_accel[i] = w.accel;
				r.disp = w.disp;
				r.vel = w.vel;
			end
			ACT_PREDICT: begin
				v0 = cur_vel[i];
				a0 = cur_accel[i];
				old_disp[i] = cur_disp[i];
				old_vel[i] = v0;
				old_accel[i] = a0;
				cur_vel[i] = round_mac(coef[REG_A1], v0, coef[REG_A2], a0, sat);
				cur_accel[i] = round_mac(coef[REG_A4], a0, coef[REG_A3], v0, sat);
				r.disp = old_disp[i];
				r.vel = alpha_blend(old_vel[i], cur_vel[i], sat);
			end
			ACT_CORRECT: begin
				cur_disp[i] = round_mac(longint'(Q_ONE), longint'(cur_disp[i]),
					longint'(Q_ONE), longint'(w.delta), sat);
				cur_vel[i] = round_mac(longint'(Q_ONE), cur_vel[i], coef[REG_C4], w.delta, sat);
				cur_accel[i] = round_mac(longint'(Q_ONE), cur_accel[i], coef[REG_C3], w.delta,
					sat);
				r.disp = alpha_blend(old_disp[i], cur_disp[i], sat);
				r.vel = alpha_blend(old_vel[i], cur_vel[i], sat);
			end
			default: begin
				r.disp = cur_disp[i];
				r.vel = cur_vel[i];
			end
		endcase
		r.accel = cur_accel[i];
		r.saturated = sat;
		expected_results.push_back(r);
	endfunction

	// sender: bursts of random length with random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready) begin
				integrate_word(pending_words[0]);
				pending_words.pop_front();
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
			if (gap_left > 0) begin
				gap_left--;
				req.valid <= 1'b0;
			end else if (pending_words.size() > 0) begin
				req.valid <= 1'b1;
				req.action <= pending_words[0].action;
				req.dof_index <= pending_words[0].dof;
				req.disp_in <= pending_words[0].disp;
				req.vel_in <= pending_words[0].vel;
				req.accel_in <= pending_words[0].accel;
				req.delta_in <= pending_words[0].delta;
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// receiver: check each word, then pick the next stall
	always @(posedge clk) begin
		dof_result_t e;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result word for dof %0d", rsp.dof_out);
					fail_count++;
				end else begin
					e = expected_results.pop_front();
					if (rsp.dof_out !== e.dof) begin
						$error("dof_out expected %0d actual %0d", e.dof, rsp.dof_out);
						fail_count++;
					end
					if (rsp.disp_out !== e.disp) begin
						$error("disp_out expected %0d actual %0d", e.disp, rsp.disp_out);
						fail_count++;
					end
					if (rsp.vel_out !== e.vel) begin
						$error("vel_out expected %0d actual %0d", e.vel, rsp.vel_out);
						fail_count++;
					end
					if (rsp.accel_out !== e.accel) begin
						$error("accel_out expected %0d actual %0d", e.accel, rsp.accel_out);
						fail_count++;
					end
					if (rsp.saturated !== e.saturated) begin
						$error("saturated expected %0d actual %0d", e.saturated,
							rsp.saturated);
						fail_count++;
					end
				end
			end
			if (hold_req && hold_count < HOLD_CYCLES) begin
				hold_count++;
				rsp.ready <= 1'b0;
			end else if (rsp_mode == 0) begin
				rsp.ready <= 1'b1;
			end else if (rsp_mode == 1) begin
				rsp.ready <= ($urandom_range(0, 9) < 7);
			end else begin
				rsp.ready <= (cycle_count[2:0] != 3'b101) && (cycle_count[5:4] != 2'b11);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("hht_alpha_dof_integrator_tb: FAIL");
			$finish;
		end
	end

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'sh0;
			3, 4, 5: return $signed(DATA_W'($urandom_range(0, 32'h3ffff))) - 32'sh20000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [COEF_W-1:0] pick_coef(input int style);
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		case (style)
			0: return 48'sh7fffffffffff;
			1: return 48'sh800000000000;
			2: return raw[COEF_W-1:0];
			default: return $signed(COEF_W'(raw[27:0])) - 48'sh8000000;
		endcase
	endfunction

	function automatic dof_word_t make_word(input logic [1:0] act, input int dof,
			input logic signed [DATA_W-1:0] d, input logic signed [DATA_W-1:0] v,
			input logic signed [DATA_W-1:0] a, input logic signed [DATA_W-1:0] dl);
		dof_word_t w;
		w.action = act;
		w.dof = IDX_W'(dof);
		w.disp = d;
		w.vel = v;
		w.accel = a;
		w.delta = dl;
		if (act == ACT_LOAD)
			now_loaded[dof] = 1'b1;
		if (act == ACT_PREDICT)
			prev_loaded[dof] = 1'b1;
		return w;
	endfunction

	// random word that never reads an entry left unwritten
	function automatic dof_word_t random_word();
		int dof;
		int pick;
		logic [1:0] act;
		dof = ($urandom_range(0, 3) != 0) ? int'(dof_pool[$urandom_range(0, POOL_SIZE - 1)])
			: int'($urandom_range(0, NUM_DOFS - 1));
		pick = $urandom_range(0, 99);
		if (pick < 15)
			act = ACT_LOAD;
		else if (pick < 45)
			act = ACT_PREDICT;
		else if (pick < 80)
			act = ACT_CORRECT;
		else
			act = ACT_COMMIT;
		if (!now_loaded[dof])
			act = ACT_LOAD;
		else if (act == ACT_CORRECT && !prev_loaded[dof])
			act = ACT_PREDICT;
		return make_word(act, dof, pick_value(), pick_value(), pick_value(), pick_value());
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic signed [COEF_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		coef[idx] = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// hold until every word is out, then let the pipe drain
	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_words.size() != 0 || expected_results.size() != 0 || req.valid);
		repeat (12) @(posedge clk);
	endtask

	initial begin
		fail_count = 0;
		cycle_count = 0;
		burst_left = 0;
		gap_left = 0;
		hold_count = 0;
		hold_req = 1'b0;
		rsp_mode = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_ALPHA;
		cfg_data = '0;
		req.valid = 1'b0;
		req.action = ACT_LOAD;
		req.dof_index = '0;
		req.disp_in = '0;
		req.vel_in = '0;
		req.accel_in = '0;
		req.delta_in = '0;
		rsp.ready = 1'b0;
		for (int i = 0; i < 7; i++)
			coef[i] = '0;
		coef[REG_A1] = Q_MONE;
		coef[REG_A4] = Q_MONE;
		for (int i = 0; i < POOL_SIZE; i++)
			dof_pool[i] = IDX_W'($urandom_range(0, NUM_DOFS - 1));
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes and every action under reset coefficients
		pending_words.push_back(make_word(ACT_LOAD, 0, 32'sh7fffffff, 32'sh7fffffff,
			32'sh7fffffff, 0));
		pending_words.push_back(make_word(ACT_LOAD, NUM_DOFS - 1, 32'sh80000000,
			32'sh80000000, 32'sh80000000, 0));
		pending_words.push_back(make_word(ACT_COMMIT, 0, 0, 0, 0, 0));
		pending_words.push_back(make_word(ACT_PREDICT, 0, 0, 0, 0, 0));
		pending_words.push_back(make_word(ACT_PREDICT, NUM_DOFS - 1, 0, 0, 0, 0));
		pending_words.push_back(make_word(ACT_CORRECT, 0, 0, 0, 0, 32'sh7fffffff));
		pending_words.push_back(make_word(ACT_CORRECT, NUM_DOFS - 1, 0, 0, 0,
			32'sh80000000));
		pending_words.push_back(make_word(ACT_CORRECT, 0, 0, 0, 0, 32'sh80000000));
		pending_words.push_back(make_word(ACT_COMMIT, NUM_DOFS - 1, 0, 0, 0, 0));
		pending_words.push_back(make_word(ACT_LOAD, 5, 0, 32'sh10000, -32'sh8000, 0));
		pending_words.push_back(make_word(ACT_PREDICT, 5, 0, 0, 0, 0));
		pending_words.push_back(make_word(ACT_CORRECT, 5, 0, 0, 0, 32'sh18000));
		pending_words.push_back(make_word(ACT_PREDICT, 5, 0, 0, 0, 0));
		pending_words.push_back(make_word(ACT_COMMIT, 5, 0, 0, 0, 0));
		pending_words.push_back(make_word(ACT_LOAD, 10'h2aa, 32'sh55555555, 32'sh2aaaaaaa,
			-32'sh1, 0));
		pending_words.push_back(make_word(ACT_LOAD, 10'h155, -32'sh55555556, 32'sh1,
			32'sh0, 32'sh55555555));
		pending_words.push_back(make_word(ACT_COMMIT, 10'h155, 0, 0, 0, 0));
		wait_idle();

		// random phases, each with a fresh register set
		for (int ph = 0; ph < 6; ph++) begin
			for (int r = 0; r < 7; r++)
				write_reg(CFG_IDX_W'(r), pick_coef(ph == 1 ? (r % 2) : (ph == 2 ? 2 : 3)));
			rsp_mode = ph % 3;
			for (int n = 0; n < PHASE_WORDS; n++)
				pending_words.push_back(random_word());
			// back-pressure the result side long enough to fill the queue
			if (ph == 3)
				hold_req = 1'b1;
			wait_idle();
		end

		if (fail_count == 0)
			$display("hht_alpha_dof_integrator_tb: PASS");
		else
			$display("hht_alpha_dof_integrator_tb: FAIL");
		$finish;
	end

endmodule
